// ===== sv/rvd_pkg.sv =====
// ----------------------------------------------------------------------------
// rvd_pkg
// shared codes and types for the rv32im instruction decoder pipeline
// ----------------------------------------------------------------------------
package rvd_pkg;

  // operation numbers
  localparam logic [5:0] OP_LW      = 6'd0;
  localparam logic [5:0] OP_LBU     = 6'd1;
  localparam logic [5:0] OP_LH      = 6'd2;
  localparam logic [5:0] OP_LHU     = 6'd3;
  localparam logic [5:0] OP_LB      = 6'd4;
  localparam logic [5:0] OP_SW      = 6'd5;
  localparam logic [5:0] OP_SB      = 6'd6;
  localparam logic [5:0] OP_SH      = 6'd7;
  localparam logic [5:0] OP_LUI     = 6'd8;
  localparam logic [5:0] OP_AUIPC   = 6'd9;
  localparam logic [5:0] OP_TRAP    = 6'd10;
  localparam logic [5:0] OP_ADDI    = 6'd11;
  localparam logic [5:0] OP_SLTI    = 6'd12;
  localparam logic [5:0] OP_SLTIU   = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_ORI     = 6'd15;
  localparam logic [5:0] OP_ANDI    = 6'd16;
  localparam logic [5:0] OP_SLLI    = 6'd17;
  localparam logic [5:0] OP_SRLI    = 6'd18;
  localparam logic [5:0] OP_SRAI    = 6'd19;
  localparam logic [5:0] OP_JAL     = 6'd20;
  localparam logic [5:0] OP_JALR    = 6'd21;
  localparam logic [5:0] OP_ADD     = 6'd22;
  localparam logic [5:0] OP_SUB     = 6'd23;
  localparam logic [5:0] OP_SLL     = 6'd24;
  localparam logic [5:0] OP_SLT     = 6'd25;
  localparam logic [5:0] OP_SLTU    = 6'd26;
  localparam logic [5:0] OP_XOR     = 6'd27;
  localparam logic [5:0] OP_SRL     = 6'd28;
  localparam logic [5:0] OP_SRA     = 6'd29;
  localparam logic [5:0] OP_OR      = 6'd30;
  localparam logic [5:0] OP_AND     = 6'd31;
  localparam logic [5:0] OP_MUL     = 6'd32;
  localparam logic [5:0] OP_MULH    = 6'd33;
  localparam logic [5:0] OP_MULHU   = 6'd34;
  localparam logic [5:0] OP_DIV     = 6'd35;
  localparam logic [5:0] OP_REM     = 6'd36;
  localparam logic [5:0] OP_DIVU    = 6'd37;
  localparam logic [5:0] OP_REMU    = 6'd38;
  localparam logic [5:0] OP_BEQ     = 6'd39;
  localparam logic [5:0] OP_BNE     = 6'd40;
  localparam logic [5:0] OP_BLT     = 6'd41;
  localparam logic [5:0] OP_BGE     = 6'd42;
  localparam logic [5:0] OP_BGEU    = 6'd43;
  localparam logic [5:0] OP_BLTU    = 6'd44;
  localparam logic [5:0] OP_CSRRWI  = 6'd45;
  localparam logic [5:0] OP_CSRRS   = 6'd46;
  localparam logic [5:0] OP_CSRRW   = 6'd47;
  localparam logic [5:0] OP_ECALL   = 6'd48;
  localparam logic [5:0] OP_MRET    = 6'd49;
  localparam logic [5:0] OP_INVALID = 6'd50;

  // operand formats
  localparam logic [2:0] FMT_I    = 3'd0;
  localparam logic [2:0] FMT_S    = 3'd1;
  localparam logic [2:0] FMT_U    = 3'd2;
  localparam logic [2:0] FMT_J    = 3'd3;
  localparam logic [2:0] FMT_R    = 3'd4;
  localparam logic [2:0] FMT_B    = 3'd5;
  localparam logic [2:0] FMT_NONE = 3'd6;

  // major opcodes
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_TRAP   = 7'h6b;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MEXT = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // upper 25 bits of mret
  localparam logic [24:0] MRET_HI = 25'h0604000;

  typedef struct packed {
    logic [31:0] word;
    logic [5:0]  op;
    logic [2:0]  fmt;
  } rvd_dec_t;

  typedef struct packed {
    logic [31:0] imm;
    logic        dest_write;
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [4:0]  rs1;
    logic [2:0]  fmt;
    logic [5:0]  op;
  } rvd_res_t;

endpackage

// ===== sv/rv32im_instruction_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_unit
// three-stage pipelined rv32im decoder: one instruction word in, one decoded
// item out
//
//   channel | dir | width | contents
//   s_*     | in  | 32    | instr_word
//   m_*     | out | 64    | op_id, format, rs1/rs2/rd index, dest_write, imm
//
// one item per cycle while m_tready keeps the pipe moving; an accepted word passes the
// input register, the group decode stage and the immediate/result stage in that
// order, and the valid bit of the last of these drives m_tvalid
// rst is synchronous and clears the stage valid bits only
// the whole pipe holds when the output item waits on m_tready; s_tready
// follows the same enable, so nothing is dropped or repeated
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] instr_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [5:0] op_id, [8:6] format, [13:9] rs1_index,
                                 // [18:14] rs2_index, [23:19] rd_index,
                                 // [24] dest_write, [56:25] imm_value, [63:57] 0
);
  import rvd_pkg::*;

  logic        advance;
  logic        v_in;
  logic [31:0] word_in;
  logic        v_dec;
  rvd_dec_t    dec;
  rvd_res_t    res;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else if (advance) begin
      v_in <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_in <= s_tdata;
    end
  end

  rvd_opdecode u_opdecode (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (v_in),
    .in_word   (word_in),
    .out_valid (v_dec),
    .out_dec   (dec)
  );

  rvd_immgen u_immgen (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (v_dec),
    .in_dec    (dec),
    .out_valid (m_tvalid),
    .out_res   (res)
  );

  assign m_tdata = {7'd0, res.imm, res.dest_write, res.rd, res.rs2, res.rs1,
                    res.fmt, res.op};

endmodule

// ===== sv/rvd_opdecode.sv =====
// ----------------------------------------------------------------------------
// rvd_opdecode
// second stage: opcode group, inner pattern match and operand format
// ----------------------------------------------------------------------------
module rvd_opdecode (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  logic [31:0]      in_word,
  output logic             out_valid,
  output rvd_pkg::rvd_dec_t out_dec
);
  import rvd_pkg::*;

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [5:0] op_next;
  logic [2:0] fmt_next;

  assign opc = in_word[6:0];
  assign f3  = in_word[14:12];
  assign f7  = in_word[31:25];

  always_comb begin
    op_next  = OP_INVALID;
    fmt_next = FMT_NONE;
    unique case (opc)
      OPC_LOAD: begin
        fmt_next = FMT_I;
        unique case (f3)
          3'd2: op_next = OP_LW;
          3'd4: op_next = OP_LBU;
          3'd1: op_next = OP_LH;
          3'd5: op_next = OP_LHU;
          3'd0: op_next = OP_LB;
          default: op_next = OP_INVALID;
        endcase
      end
      OPC_STORE: begin
        fmt_next = FMT_S;
        unique case (f3)
          3'd2: op_next = OP_SW;
          3'd0: op_next = OP_SB;
          3'd1: op_next = OP_SH;
          default: op_next = OP_INVALID;
        endcase
      end
      OPC_LUI: begin
        fmt_next = FMT_U;
        op_next  = OP_LUI;
      end
      OPC_AUIPC: begin
        fmt_next = FMT_U;
        op_next  = OP_AUIPC;
      end
      OPC_TRAP: begin
        fmt_next = FMT_NONE;
        op_next  = OP_TRAP;
      end
      OPC_IMM: begin
        fmt_next = FMT_I;
        unique case (f3)
          3'd0: op_next = OP_ADDI;
          3'd2: op_next = OP_SLTI;
          3'd3: op_next = OP_SLTIU;
          3'd4: op_next = OP_XORI;
          3'd6: op_next = OP_ORI;
          3'd7: op_next = OP_ANDI;
          3'd1: op_next = OP_SLLI;
          default: begin
            // right shifts pick by funct7
            if (f7 == F7_BASE)     op_next = OP_SRLI;
            else if (f7 == F7_ALT) op_next = OP_SRAI;
            else                   op_next = OP_INVALID;
          end
        endcase
      end
      OPC_JAL: begin
        fmt_next = FMT_J;
        op_next  = OP_JAL;
      end
      OPC_JALR: begin
        fmt_next = FMT_I;
        op_next  = OP_JALR;
      end
      OPC_REG: begin
        fmt_next = FMT_R;
        if (f7 == F7_BASE) begin
          unique case (f3)
            3'd0: op_next = OP_ADD;
            3'd1: op_next = OP_SLL;
            3'd2: op_next = OP_SLT;
            3'd3: op_next = OP_SLTU;
            3'd4: op_next = OP_XOR;
            3'd5: op_next = OP_SRL;
            3'd6: op_next = OP_OR;
            default: op_next = OP_AND;
          endcase
        end else if (f7 == F7_MEXT) begin
          unique case (f3)
            3'd0: op_next = OP_MUL;
            3'd1: op_next = OP_MULH;
            3'd3: op_next = OP_MULHU;
            3'd4: op_next = OP_DIV;
            3'd5: op_next = OP_DIVU;
            3'd6: op_next = OP_REM;
            3'd7: op_next = OP_REMU;
            default: op_next = OP_INVALID;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          op_next = OP_SUB;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          op_next = OP_SRA;
        end
      end
      OPC_BRANCH: begin
        fmt_next = FMT_B;
        unique case (f3)
          3'd0: op_next = OP_BEQ;
          3'd1: op_next = OP_BNE;
          3'd4: op_next = OP_BLT;
          3'd5: op_next = OP_BGE;
          3'd6: op_next = OP_BLTU;
          3'd7: op_next = OP_BGEU;
          default: op_next = OP_INVALID;
        endcase
      end
      OPC_SYSTEM: begin
        fmt_next = FMT_I;
        if (f3 == 3'd5)                                op_next = OP_CSRRWI;
        else if (f3 == 3'd2)                           op_next = OP_CSRRS;
        else if (f3 == 3'd1)                           op_next = OP_CSRRW;
        else if (f3 == 3'd0 && in_word[24:20] == 5'd0) op_next = OP_ECALL;
        else if (in_word[31:7] == MRET_HI)             op_next = OP_MRET;
      end
      default: begin
        op_next  = OP_INVALID;
        fmt_next = FMT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dec.word <= in_word;
      out_dec.op   <= op_next;
      out_dec.fmt  <= fmt_next;
    end
  end

endmodule

// ===== sv/rvd_immgen.sv =====
// ----------------------------------------------------------------------------
// rvd_immgen
// third stage: immediate assembly, write enable and result register
// ----------------------------------------------------------------------------
module rvd_immgen (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  rvd_pkg::rvd_dec_t in_dec,
  output logic              out_valid,
  output rvd_pkg::rvd_res_t out_res
);
  import rvd_pkg::*;

  logic [31:0] w;
  logic [31:0] imm_next;
  logic        dw_next;

  assign w = in_dec.word;

  always_comb begin
    unique case (in_dec.fmt)
      FMT_I:   imm_next = {{20{w[31]}}, w[31:20]};
      FMT_S:   imm_next = {{20{w[31]}}, w[31:25], w[11:7]};
      FMT_U:   imm_next = {w[31:12], 12'd0};
      FMT_J:   imm_next = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      FMT_B:   imm_next = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      default: imm_next = 32'd0;
    endcase
  end

  // stores and branches use the rd slot for immediate bits
  assign dw_next = (in_dec.fmt == FMT_I || in_dec.fmt == FMT_U ||
                    in_dec.fmt == FMT_J || in_dec.fmt == FMT_R) &&
                   (w[11:7] != 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res.op         <= in_dec.op;
      out_res.fmt        <= in_dec.fmt;
      out_res.rs1        <= w[19:15];
      out_res.rs2        <= w[24:20];
      out_res.rd         <= w[11:7];
      out_res.dest_write <= dw_next;
      out_res.imm        <= imm_next;
    end
  end

endmodule

// ===== tb/rv32im_instruction_decoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_unit_tb
// self-checking bench for the pipelined rv32im decoder: a short table of
// hand-picked instruction words, then random words that are mostly drawn from
// the known opcode groups, most decoded by an in-bench decoder and compared
// field by field with every item that leaves the block, under random stalls
// on both streams
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder_unit_tb;
  import rvd_pkg::*;

  localparam int RANDOM_ITEMS   = 1975;
  localparam int DRAIN_AT       = 1500;
  localparam int CALM_FIRST     = 900;
  localparam int CALM_LAST      = 1200;
  localparam int HOLD_AFTER     = 600;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam rvd_res_t NO_WANT  = '0;

  localparam logic [6:0] MAJOR_OPCODES [11] = '{
    OPC_LOAD, OPC_STORE, OPC_LUI, OPC_AUIPC, OPC_TRAP, OPC_IMM,
    OPC_JAL, OPC_JALR, OPC_REG, OPC_BRANCH, OPC_SYSTEM
  };

  // typed marks a row whose expected decode is written out here
  typedef struct packed {
    logic [31:0] word;
    logic        typed;
    rvd_res_t    want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [26] = '{
    '{32'h0000_0000, 1'b1, '{32'd0, 1'b0, 5'd0, 5'd0, 5'd0, FMT_NONE, OP_INVALID}},
    '{32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0, 5'd31, 5'd31, 5'd31, FMT_NONE, OP_INVALID}},
    '{32'hFFFF_FFEB, 1'b1, '{32'd0, 1'b0, 5'd31, 5'd31, 5'd31, FMT_NONE, OP_TRAP}},
    '{32'h0000_0073, 1'b1, '{32'd0, 1'b0, 5'd0, 5'd0, 5'd0, FMT_I, OP_ECALL}},
    '{32'h3020_0073, 1'b1, '{32'h302, 1'b0, 5'd0, 5'd2, 5'd0, FMT_I, OP_MRET}},
    '{32'h0001_2083, 1'b0, NO_WANT},   // lw
    '{32'hFFF0_3003, 1'b0, NO_WANT},   // load group, no inner match, rd 0
    '{32'h7FF4_4F83, 1'b0, NO_WANT},   // lbu, largest positive immediate
    '{32'hFE00_0FA3, 1'b0, NO_WANT},   // sb, immediate -1
    '{32'h0000_3023, 1'b0, NO_WANT},   // store group, no inner match
    '{32'hFFFF_F0B7, 1'b0, NO_WANT},   // lui
    '{32'h8000_0017, 1'b0, NO_WANT},   // auipc to x0
    '{32'h4000_D093, 1'b0, NO_WANT},   // srai
    '{32'hFE00_9093, 1'b0, NO_WANT},   // slli ignores funct7
    '{32'h0200_D093, 1'b0, NO_WANT},   // right shift with unknown funct7
    '{32'h8000_00EF, 1'b0, NO_WANT},   // jal, most negative offset
    '{32'h7FFF_F06F, 1'b0, NO_WANT},   // jal, most positive offset, rd 0
    '{32'hFFF0_80E7, 1'b0, NO_WANT},   // jalr
    '{32'h4000_0033, 1'b0, NO_WANT},   // sub to x0
    '{32'h0200_A0B3, 1'b0, NO_WANT},   // m extension hole
    '{32'h7E00_00B3, 1'b0, NO_WANT},   // register group, unknown funct7
    '{32'h8000_0FE3, 1'b0, NO_WANT},   // beq, negative offset
    '{32'h0000_2063, 1'b0, NO_WANT},   // branch hole
    '{32'h0000_E063, 1'b0, NO_WANT},   // bltu
    '{32'h302F_5F73, 1'b0, NO_WANT},   // csrrwi
    '{32'h3020_00F3, 1'b0, NO_WANT}    // mret look-alike with rd set
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  // expected decode that travels with the offered word
  rvd_res_t    s_want = '0;
  logic        calm = 1'b0;

  rvd_res_t    pending_decodes [$];
  int          words_accepted = 0;
  int          decodes_checked = 0;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit [63:0]   op_seen = '0;

  rv32im_instruction_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rvd_res_t decode_word(input logic [31:0] w);
    rvd_res_t   r;
    logic [2:0] f3;
    logic [6:0] f7;
    f3 = w[14:12];
    f7 = w[31:25];
    r = '0;
    r.op = OP_INVALID;
    r.fmt = FMT_NONE;
    r.rs1 = w[19:15];
    r.rs2 = w[24:20];
    r.rd = w[11:7];
    case (w[6:0])
      OPC_LOAD: begin
        r.fmt = FMT_I;
        case (f3)
          3'd2: r.op = OP_LW;
          3'd4: r.op = OP_LBU;
          3'd1: r.op = OP_LH;
          3'd5: r.op = OP_LHU;
          3'd0: r.op = OP_LB;
          default: r.op = OP_INVALID;
        endcase
      end
      OPC_STORE: begin
        r.fmt = FMT_S;
        case (f3)
          3'd2: r.op = OP_SW;
          3'd0: r.op = OP_SB;
          3'd1: r.op = OP_SH;
          default: r.op = OP_INVALID;
        endcase
      end
      OPC_LUI: begin
        r.fmt = FMT_U;
        r.op = OP_LUI;
      end
      OPC_AUIPC: begin
        r.fmt = FMT_U;
        r.op = OP_AUIPC;
      end
      OPC_TRAP: r.op = OP_TRAP;
      OPC_IMM: begin
        r.fmt = FMT_I;
        case (f3)
          3'd0: r.op = OP_ADDI;
          3'd2: r.op = OP_SLTI;
          3'd3: r.op = OP_SLTIU;
          3'd4: r.op = OP_XORI;
          3'd6: r.op = OP_ORI;
          3'd7: r.op = OP_ANDI;
          3'd1: r.op = OP_SLLI;
          default: begin
            if (f7 == F7_BASE) r.op = OP_SRLI;
            else if (f7 == F7_ALT) r.op = OP_SRAI;
          end
        endcase
      end
      OPC_JAL: begin
        r.fmt = FMT_J;
        r.op = OP_JAL;
      end
      OPC_JALR: begin
        r.fmt = FMT_I;
        r.op = OP_JALR;
      end
      OPC_REG: begin
        r.fmt = FMT_R;
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: r.op = OP_ADD;
            3'd1: r.op = OP_SLL;
            3'd2: r.op = OP_SLT;
            3'd3: r.op = OP_SLTU;
            3'd4: r.op = OP_XOR;
            3'd5: r.op = OP_SRL;
            3'd6: r.op = OP_OR;
            default: r.op = OP_AND;
          endcase
        end else if (f7 == F7_MEXT) begin
          case (f3)
            3'd0: r.op = OP_MUL;
            3'd1: r.op = OP_MULH;
            3'd3: r.op = OP_MULHU;
            3'd4: r.op = OP_DIV;
            3'd5: r.op = OP_DIVU;
            3'd6: r.op = OP_REM;
            3'd7: r.op = OP_REMU;
            default: r.op = OP_INVALID;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) r.op = OP_SUB;
          else if (f3 == 3'd5) r.op = OP_SRA;
        end
      end
      OPC_BRANCH: begin
        r.fmt = FMT_B;
        case (f3)
          3'd0: r.op = OP_BEQ;
          3'd1: r.op = OP_BNE;
          3'd4: r.op = OP_BLT;
          3'd5: r.op = OP_BGE;
          3'd6: r.op = OP_BLTU;
          3'd7: r.op = OP_BGEU;
          default: r.op = OP_INVALID;
        endcase
      end
      OPC_SYSTEM: begin
        r.fmt = FMT_I;
        if (f3 == 3'd5) r.op = OP_CSRRWI;
        else if (f3 == 3'd2) r.op = OP_CSRRS;
        else if (f3 == 3'd1) r.op = OP_CSRRW;
        else if (f3 == 3'd0 && w[24:20] == 5'd0) r.op = OP_ECALL;
        else if (w[31:7] == MRET_HI) r.op = OP_MRET;
      end
      default: ;
    endcase
    case (r.fmt)
      FMT_I: r.imm = {{20{w[31]}}, w[31:20]};
      FMT_S: r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
      FMT_U: r.imm = {w[31:12], 12'd0};
      FMT_J: r.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      FMT_B: r.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      default: r.imm = '0;
    endcase
    r.dest_write = (r.fmt == FMT_I || r.fmt == FMT_U || r.fmt == FMT_J ||
                    r.fmt == FMT_R) && r.rd != 5'd0;
    return r;
  endfunction

  // mostly words from a known group with random content, some pure noise
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(99) < 8) return w;
    w[6:0] = MAJOR_OPCODES[$urandom_range(10)];
    if (w[6:0] == OPC_REG || w[6:0] == OPC_IMM) begin
      case ($urandom_range(3))
        0: w[31:25] = F7_BASE;
        1: w[31:25] = F7_MEXT;
        2: w[31:25] = F7_ALT;
        default: ;
      endcase
    end
    if (w[6:0] == OPC_SYSTEM) begin
      case ($urandom_range(3))
        0: w = {MRET_HI, OPC_SYSTEM};
        1: begin
          w[14:12] = 3'd0;
          w[24:20] = 5'd0;
        end
        default: ;
      endcase
    end
    if ($urandom_range(7) == 0) w[11:7] = 5'd0;
    return w;
  endfunction

  task automatic send_word(input logic [31:0] w, input rvd_res_t want);
    while (!calm && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    s_want <= want;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_decodes();
    s_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    fail_count++;
  endtask

  // output check, expectation store, ready pattern and watchdog
  always @(posedge clk) begin
    rvd_res_t want;
    rvd_res_t got;
    if (!rst) begin
      quiet_cycles++;
      if (m_tvalid && m_tready) begin
        quiet_cycles = 0;
        got = rvd_res_t'(m_tdata[56:0]);
        op_seen[got.op] = 1'b1;
        if (pending_decodes.size() == 0) begin
          $display("%0t: unexpected item, got %0h", $time, m_tdata);
          fail_count++;
        end else begin
          want = pending_decodes.pop_front();
          decodes_checked++;
          if (got.op !== want.op)
            flag_field("op_id", 32'(want.op), 32'(got.op));
          if (got.fmt !== want.fmt)
            flag_field("format", 32'(want.fmt), 32'(got.fmt));
          if (got.rs1 !== want.rs1)
            flag_field("rs1_index", 32'(want.rs1), 32'(got.rs1));
          if (got.rs2 !== want.rs2)
            flag_field("rs2_index", 32'(want.rs2), 32'(got.rs2));
          if (got.rd !== want.rd)
            flag_field("rd_index", 32'(want.rd), 32'(got.rd));
          if (got.dest_write !== want.dest_write)
            flag_field("dest_write", 32'(want.dest_write), 32'(got.dest_write));
          if (got.imm !== want.imm) flag_field("imm_value", want.imm, got.imm);
          if (m_tdata[63:57] !== 7'd0)
            flag_field("padding", 32'd0, 32'(m_tdata[63:57]));
        end
      end
      if (s_tvalid && s_tready) begin
        quiet_cycles = 0;
        words_accepted++;
        pending_decodes.push_back(s_want);
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("FAIL rv32im_instruction_decoder_unit");
        $finish;
      end
    end
    // one long hold-off once enough items have gone by, so the pipe backs up
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && decodes_checked >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 28);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED_ROWS[i])
      send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed ?
                DIRECTED_ROWS[i].want : decode_word(DIRECTED_ROWS[i].word));
    drain_decodes();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      logic [31:0] w;
      w = random_word();
      calm <= (n >= CALM_FIRST && n < CALM_LAST);
      if (n == DRAIN_AT) drain_decodes();
      send_word(w, decode_word(w));
    end
    drain_decodes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_decodes.size() != 0) begin
      $display("%0t: %0d decodes never arrived", $time, pending_decodes.size());
      fail_count++;
    end
    $display("decoded %0d words (%0d from the directed table), %0d items checked",
             words_accepted, $size(DIRECTED_ROWS), decodes_checked);
    $display("saw %0d of 51 operation codes, %0d mismatches",
             $countones(op_seen[50:0]), fail_count);
    if (fail_count == 0) begin
      $display("PASS rv32im_instruction_decoder_unit");
    end else begin
      $display("FAIL rv32im_instruction_decoder_unit");
    end
    $finish;
  end

endmodule
